[design/obd_pid_value_decode_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef OBD_PID_VALUE_DECODE_TOP_ASSERT_SVH
`define OBD_PID_VALUE_DECODE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OPVD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("opvd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OPVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("opvd assertion failed");

`endif

[design/opvd_pkg.sv]
package opvd_pkg;

    localparam logic [7:0] RESP_CODE = 8'h41;

    // Mode 01 PIDs with a known formula
    localparam logic [7:0] PID_LOAD      = 8'h04;
    localparam logic [7:0] PID_COOLANT   = 8'h05;
    localparam logic [7:0] PID_STFT1     = 8'h06;
    localparam logic [7:0] PID_LTFT1     = 8'h07;
    localparam logic [7:0] PID_MAP       = 8'h0B;
    localparam logic [7:0] PID_RPM       = 8'h0C;
    localparam logic [7:0] PID_SPEED     = 8'h0D;
    localparam logic [7:0] PID_TIMING    = 8'h0E;
    localparam logic [7:0] PID_IAT       = 8'h0F;
    localparam logic [7:0] PID_MAF       = 8'h10;
    localparam logic [7:0] PID_THROTTLE  = 8'h11;
    localparam logic [7:0] PID_RUNTIME   = 8'h1F;
    localparam logic [7:0] PID_MIL_DIST  = 8'h21;
    localparam logic [7:0] PID_FUEL_LVL  = 8'h2F;
    localparam logic [7:0] PID_BARO      = 8'h33;
    localparam logic [7:0] PID_VOLTAGE   = 8'h42;
    localparam logic [7:0] PID_AMBIENT   = 8'h46;
    localparam logic [7:0] PID_OIL_TEMP  = 8'h5C;
    localparam logic [7:0] PID_FUEL_RATE = 8'h5E;

    localparam int VALUE_W = 27;
    localparam int PCT_W   = 17;
    localparam int PCT_DIV = 510;
    localparam int PCT_MUL = 200000;

    typedef enum logic [4:0] {
        SIG_LOAD, SIG_COOLANT, SIG_STFT1, SIG_LTFT1, SIG_MAP, SIG_RPM, SIG_SPEED,
        SIG_TIMING, SIG_IAT, SIG_MAF, SIG_THROTTLE, SIG_RUNTIME, SIG_MIL_DIST,
        SIG_FUEL_LVL, SIG_BARO, SIG_VOLTAGE, SIG_AMBIENT, SIG_OIL_TEMP,
        SIG_FUEL_RATE, SIG_RAW
    } t_sig;

    typedef struct packed {
        logic       match;
        logic [7:0] a;
        logic [7:0] b;
    } t_layout;

    typedef logic [255:0][PCT_W-1:0] t_pct_tbl;

    // A*100000/255, round half up, for every A
    function automatic t_pct_tbl f_build_pct();
        t_pct_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = PCT_W'((i * PCT_MUL + 255) / PCT_DIV);
        end
        return tbl;
    endfunction

    localparam t_pct_tbl PCT_TBL = f_build_pct();

    function automatic t_sig f_sig_code(input logic [7:0] pid);
        t_sig code;
        case (pid)
            PID_LOAD:      code = SIG_LOAD;
            PID_COOLANT:   code = SIG_COOLANT;
            PID_STFT1:     code = SIG_STFT1;
            PID_LTFT1:     code = SIG_LTFT1;
            PID_MAP:       code = SIG_MAP;
            PID_RPM:       code = SIG_RPM;
            PID_SPEED:     code = SIG_SPEED;
            PID_TIMING:    code = SIG_TIMING;
            PID_IAT:       code = SIG_IAT;
            PID_MAF:       code = SIG_MAF;
            PID_THROTTLE:  code = SIG_THROTTLE;
            PID_RUNTIME:   code = SIG_RUNTIME;
            PID_MIL_DIST:  code = SIG_MIL_DIST;
            PID_FUEL_LVL:  code = SIG_FUEL_LVL;
            PID_BARO:      code = SIG_BARO;
            PID_VOLTAGE:   code = SIG_VOLTAGE;
            PID_AMBIENT:   code = SIG_AMBIENT;
            PID_OIL_TEMP:  code = SIG_OIL_TEMP;
            PID_FUEL_RATE: code = SIG_FUEL_RATE;
            default:       code = SIG_RAW;
        endcase
        return code;
    endfunction

endpackage

[design/opvd_layout.sv]
module opvd_layout (
    input  logic [7:0]       i_pid,
    input  logic [3:0]       i_len,
    input  logic [7:0]       i_b0,
    input  logic [7:0]       i_b1,
    input  logic [7:0]       i_b2,
    input  logic [7:0]       i_b3,
    input  logic [7:0]       i_b4,
    output opvd_pkg::t_layout o_layout
);
    import opvd_pkg::*;

    logic single_frame;
    logic bare;

    assign single_frame = (i_len >= 4'd3) && (i_b1 == RESP_CODE) && (i_b2 == i_pid);
    assign bare         = (i_len >= 4'd2) && (i_b0 == RESP_CODE) && (i_b1 == i_pid);

    // payload bytes past the frame length read as zero
    always_comb begin
        o_layout = '0;
        if (single_frame) begin
            o_layout.match = 1'b1;
            o_layout.a     = (i_len > 4'd3) ? i_b3 : 8'd0;
            o_layout.b     = (i_len > 4'd4) ? i_b4 : 8'd0;
        end else if (bare) begin
            o_layout.match = 1'b1;
            o_layout.a     = (i_len > 4'd2) ? i_b2 : 8'd0;
            o_layout.b     = (i_len > 4'd3) ? i_b3 : 8'd0;
        end
    end

endmodule

[design/opvd_formula.sv]
module opvd_formula (
    input  logic [7:0]                    i_pid,
    input  opvd_pkg::t_layout             i_layout,
    output logic                          o_valid,
    output logic [4:0]                    o_code,
    output logic [opvd_pkg::VALUE_W-1:0]  o_value
);
    import opvd_pkg::*;

    logic signed [VALUE_W-1:0] a_s;
    logic signed [VALUE_W-1:0] ab_s;
    logic signed [VALUE_W-1:0] trim_q;
    logic signed [VALUE_W-1:0] trim_mag;
    logic signed [VALUE_W-1:0] trim_rnd;
    logic signed [VALUE_W-1:0] value;

    assign a_s  = signed'(VALUE_W'(i_layout.a));
    assign ab_s = signed'(VALUE_W'({i_layout.a, i_layout.b}));

    // fuel trim: (A-128)*3125/4, ties away from zero
    assign trim_q   = (a_s - VALUE_W'(128)) * VALUE_W'(3125);
    assign trim_mag = trim_q[VALUE_W-1] ? -trim_q : trim_q;
    assign trim_rnd = (trim_mag + VALUE_W'(2)) >>> 2;

    always_comb begin
        case (i_pid)
            PID_LOAD, PID_THROTTLE, PID_FUEL_LVL:
                value = signed'(VALUE_W'(PCT_TBL[i_layout.a]));
            PID_COOLANT, PID_IAT, PID_AMBIENT, PID_OIL_TEMP:
                value = (a_s - VALUE_W'(40)) * VALUE_W'(1000);
            PID_STFT1, PID_LTFT1:
                value = trim_q[VALUE_W-1] ? -trim_rnd : trim_rnd;
            PID_RPM:       value = ab_s * VALUE_W'(250);
            PID_TIMING:    value = a_s * VALUE_W'(500) - VALUE_W'(64000);
            PID_MAF:       value = ab_s * VALUE_W'(10);
            PID_RUNTIME, PID_MIL_DIST:
                value = ab_s * VALUE_W'(1000);
            PID_VOLTAGE:   value = ab_s;
            PID_FUEL_RATE: value = ab_s * VALUE_W'(50);
            default:       value = a_s * VALUE_W'(1000);
        endcase
    end

    assign o_valid = i_layout.match;
    assign o_code  = i_layout.match ? 5'(f_sig_code(i_pid)) : 5'd0;
    assign o_value = i_layout.match ? VALUE_W'(value) : '0;

endmodule

[design/obd_pid_value_decode_top.sv]
// OBD-II mode 01 response decoder. Pulse start with the requested PID, the
// frame length and frame bytes 0..4; busy never rises, so a frame can be
// issued every clock. Each frame yields exactly one result:
// o_res_strobe is high for one cycle with o_valid_res, o_signal_code and
// o_value_milli (thousandths of the unit, signed). The result is not held:
// the receiver must take it in that cycle, as it cannot stall the block.
// The result passes through the input register and then the result register,
// with the layout match and the formula evaluated between them.
module obd_pid_value_decode_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    i_pid,
    input  logic [3:0]                    i_frame_len,
    input  logic [7:0]                    i_frame_byte0,
    input  logic [7:0]                    i_frame_byte1,
    input  logic [7:0]                    i_frame_byte2,
    input  logic [7:0]                    i_frame_byte3,
    input  logic [7:0]                    i_frame_byte4,
    output logic                          o_res_strobe,
    output logic                          o_valid_res,
    output logic [4:0]                    o_signal_code,
    output logic [opvd_pkg::VALUE_W-1:0]  o_value_milli
);
    import opvd_pkg::*;

    logic               r_in_vld;
    logic [7:0]         r_pid;
    logic [3:0]         r_len;
    logic [7:0]         r_b0;
    logic [7:0]         r_b1;
    logic [7:0]         r_b2;
    logic [7:0]         r_b3;
    logic [7:0]         r_b4;

    logic               r_res_vld;
    logic               r_valid;
    logic [4:0]         r_code;
    logic [VALUE_W-1:0] r_value;

    logic               n_valid;
    logic [4:0]         n_code;
    logic [VALUE_W-1:0] n_value;
    t_layout            layout;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_res_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_pid <= i_pid;
            r_len <= i_frame_len;
            r_b0  <= i_frame_byte0;
            r_b1  <= i_frame_byte1;
            r_b2  <= i_frame_byte2;
            r_b3  <= i_frame_byte3;
            r_b4  <= i_frame_byte4;
        end
        if (r_in_vld) begin
            r_valid <= n_valid;
            r_code  <= n_code;
            r_value <= n_value;
        end
    end

    opvd_layout u_layout (
        .i_pid    (r_pid),
        .i_len    (r_len),
        .i_b0     (r_b0),
        .i_b1     (r_b1),
        .i_b2     (r_b2),
        .i_b3     (r_b3),
        .i_b4     (r_b4),
        .o_layout (layout)
    );

    opvd_formula u_formula (
        .i_pid    (r_pid),
        .i_layout (layout),
        .o_valid  (n_valid),
        .o_code   (n_code),
        .o_value  (n_value)
    );

    assign o_res_strobe  = r_res_vld;
    assign o_valid_res   = r_valid;
    assign o_signal_code = r_code;
    assign o_value_milli = r_value;

endmodule

[design/opvd_checker.sv]
`include "obd_pid_value_decode_top_assert.svh"

module opvd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_res_strobe,
    input logic       o_valid_res,
    input logic [4:0] o_signal_code,
    input logic [26:0] o_value_milli
);

    // a taken transfer, with reset released since, raises the result strobe
`OPVD_ASSERT_NOW(a_result_follows, i_clk, i_rst_n,
    $past(start && !busy, 2) && $past(i_rst_n, 1) && $past(i_rst_n, 2), o_res_strobe)
`OPVD_ASSERT_NOW(a_no_spurious, i_clk, i_rst_n, o_res_strobe, $past(start && !busy, 2))
`OPVD_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, o_res_strobe && !o_valid_res,
    (o_signal_code == 5'd0) && (o_value_milli == 27'd0))
`OPVD_ASSERT_NOW(a_code_range, i_clk, i_rst_n, o_res_strobe, o_signal_code <= 5'd19)

endmodule

bind obd_pid_value_decode_top opvd_checker u_opvd_checker (.*);

[verif/obd_pid_value_decode_top_tb.sv]
module obd_pid_value_decode_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import opvd_pkg::*;

    typedef struct packed {
        logic [7:0]      pid;
        logic [3:0]      len;
        logic [4:0][7:0] by;
    } t_frame;

    typedef struct packed {
        logic               valid;
        t_sig               code;
        logic [VALUE_W-1:0] value;
    } t_decode;

    // known PIDs in signal-code order, entry 0 is code 0
    localparam logic [18:0][7:0] KNOWN_PIDS = {
        PID_FUEL_RATE, PID_OIL_TEMP, PID_AMBIENT, PID_VOLTAGE, PID_BARO,
        PID_FUEL_LVL, PID_MIL_DIST, PID_RUNTIME, PID_THROTTLE, PID_MAF,
        PID_IAT, PID_TIMING, PID_SPEED, PID_RPM, PID_MAP,
        PID_LTFT1, PID_STFT1, PID_COOLANT, PID_LOAD
    };

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic [7:0]         i_pid         = '0;
    logic [3:0]         i_frame_len   = '0;
    logic [7:0]         i_frame_byte0 = '0;
    logic [7:0]         i_frame_byte1 = '0;
    logic [7:0]         i_frame_byte2 = '0;
    logic [7:0]         i_frame_byte3 = '0;
    logic [7:0]         i_frame_byte4 = '0;
    logic               o_res_strobe;
    logic               o_valid_res;
    logic [4:0]         o_signal_code;
    logic [VALUE_W-1:0] o_value_milli;

    t_decode     expected_decodes[$];
    int unsigned fault_count = 0;
    logic        gaps_on     = 1'b1;

    always #5 i_clk = ~i_clk;

    obd_pid_value_decode_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pid         (i_pid),
        .i_frame_len   (i_frame_len),
        .i_frame_byte0 (i_frame_byte0),
        .i_frame_byte1 (i_frame_byte1),
        .i_frame_byte2 (i_frame_byte2),
        .i_frame_byte3 (i_frame_byte3),
        .i_frame_byte4 (i_frame_byte4),
        .o_res_strobe  (o_res_strobe),
        .o_valid_res   (o_valid_res),
        .o_signal_code (o_signal_code),
        .o_value_milli (o_value_milli)
    );

    function automatic t_decode decode_frame(input t_frame f);
        t_decode d;
        int      off;
        int      a;
        int      b;
        int      ab;
        int      q;
        int      v;
        d.valid = 1'b0;
        d.code  = SIG_LOAD;
        d.value = '0;
        // single-frame layout wins when both match
        if (f.len >= 3 && f.by[1] == RESP_CODE && f.by[2] == f.pid) begin
            off = 3;
        end else if (f.len >= 2 && f.by[0] == RESP_CODE && f.by[1] == f.pid) begin
            off = 2;
        end else begin
            return d;
        end
        a  = (off < f.len) ? int'(f.by[off]) : 0;
        b  = (off + 1 < f.len) ? int'(f.by[off + 1]) : 0;
        ab = a * 256 + b;
        d.code = SIG_RAW;
        for (int i = 0; i < 19; i++) begin
            if (KNOWN_PIDS[i] == f.pid) d.code = t_sig'(i);
        end
        case (f.pid)
            PID_LOAD, PID_THROTTLE, PID_FUEL_LVL: v = (a * 200000 + 255) / 510;
            PID_COOLANT, PID_IAT, PID_AMBIENT, PID_OIL_TEMP: v = (a - 40) * 1000;
            PID_STFT1, PID_LTFT1: begin
                // 781.25 per step, ties away from zero
                q = (a - 128) * 3125;
                v = (q < 0) ? -((-q + 2) / 4) : (q + 2) / 4;
            end
            PID_RPM:                  v = ab * 250;
            PID_TIMING:               v = a * 500 - 64000;
            PID_MAF:                  v = ab * 10;
            PID_RUNTIME, PID_MIL_DIST: v = ab * 1000;
            PID_VOLTAGE:              v = ab;
            PID_FUEL_RATE:            v = ab * 50;
            default:                  v = a * 1000;
        endcase
        d.valid = 1'b1;
        d.value = VALUE_W'(v);
        return d;
    endfunction

    function automatic t_frame make_frame(input logic [7:0] pid, input logic [3:0] len,
                                          input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [7:0] b4);
        t_frame f;
        f.pid = pid;
        f.len = len;
        f.by  = {b4, b3, b2, b1, b0};
        return f;
    endfunction

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("ERROR at %0t: %s", $time, msg);
    endtask

    // called at a rising edge; returns at the edge where the transfer happened
    task automatic send_frame(input t_frame f);
        int gap;
        gap = gaps_on ? $urandom_range(7, 0) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_pid         <= f.pid;
        i_frame_len   <= f.len;
        i_frame_byte0 <= f.by[0];
        i_frame_byte1 <= f.by[1];
        i_frame_byte2 <= f.by[2];
        i_frame_byte3 <= f.by[3];
        i_frame_byte4 <= f.by[4];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_decodes.insert(expected_decodes.size(), decode_frame(f));
    endtask

    task automatic wait_for_results(input int max_cycles);
        int n;
        n = 0;
        start <= 1'b0;
        while (expected_decodes.size() != 0 && n < max_cycles) begin
            @(posedge i_clk);
            n++;
        end
        if (expected_decodes.size() != 0) begin
            report_fault($sformatf("%0d results never arrived", expected_decodes.size()));
        end
    endtask

    task automatic test_known_pids();
        logic [7:0] a;
        logic [7:0] pid;
        for (int i = 0; i < 20; i++) begin
            pid = (i < 19) ? KNOWN_PIDS[i] : 8'hFF;
            case (i % 5)
                0:       a = 8'h00;
                1:       a = 8'hFF;
                2:       a = 8'h80;
                3:       a = 8'h7F;
                default: a = 8'h01;
            endcase
            send_frame(make_frame(pid, 4'd8, 8'h07, RESP_CODE, pid, a, ~a));
        end
    endtask

    task automatic test_special_frames();
        // neither layout matches
        send_frame(make_frame(PID_RPM, 4'd8, 8'h00, RESP_CODE, PID_SPEED, 8'h12, 8'h34));
        // short single frame: B beyond the length
        send_frame(make_frame(PID_RPM, 4'd4, 8'h03, RESP_CODE, PID_RPM, 8'hFF, 8'hFF));
        // single frame cut to three bytes: A and B both read zero
        send_frame(make_frame(PID_RPM, 4'd3, 8'h03, RESP_CODE, PID_RPM, 8'hFF, 8'hFF));
        // bare layout at its minimum length, then with A only
        send_frame(make_frame(PID_MAF, 4'd2, RESP_CODE, PID_MAF, 8'hFF, 8'hFF, 8'hFF));
        send_frame(make_frame(PID_MAF, 4'd3, RESP_CODE, PID_MAF, 8'hFF, 8'hFF, 8'hFF));
        // too short for either layout
        send_frame(make_frame(PID_MAF, 4'd1, RESP_CODE, PID_MAF, 8'hFF, 8'hFF, 8'hFF));
        send_frame(make_frame(PID_COOLANT, 4'd2, 8'h00, RESP_CODE, PID_COOLANT, 8'h55, 8'h00));
        // length beyond eight taken as is
        send_frame(make_frame(PID_VOLTAGE, 4'd15, RESP_CODE, PID_VOLTAGE, 8'hAB, 8'hCD, 8'hEF));
        // both layouts match when pid equals the response code
        send_frame(make_frame(RESP_CODE, 4'd5, RESP_CODE, RESP_CODE, RESP_CODE, 8'h7E, 8'h99));
        // fuel trim rounding ties on both sides of zero
        send_frame(make_frame(PID_STFT1, 4'd8, 8'h04, RESP_CODE, PID_STFT1, 8'd130, 8'h00));
        send_frame(make_frame(PID_LTFT1, 4'd8, 8'h04, RESP_CODE, PID_LTFT1, 8'd126, 8'h00));
    endtask

    task automatic test_random_frames(input int count);
        t_frame f;
        int     sel;
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) gaps_on = ($urandom_range(2, 0) != 0);
            f.pid = ($urandom_range(3, 0) != 0) ? KNOWN_PIDS[$urandom_range(18, 0)]
                                                : 8'($urandom);
            f.len = ($urandom_range(7, 0) != 0) ? 4'($urandom_range(8, 2))
                                                : 4'($urandom_range(15, 0));
            f.by  = {8'($urandom), 32'($urandom)};
            sel   = $urandom_range(9, 0);
            if (sel < 4) begin
                f.by[1] = RESP_CODE;
                f.by[2] = f.pid;
            end else if (sel < 8) begin
                f.by[0] = RESP_CODE;
                f.by[1] = f.pid;
            end
            // sender holds off until the pipeline has emptied
            if (i == count / 2) wait_for_results(64);
            send_frame(f);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_decode want;
        if (i_rst_n && o_res_strobe) begin
            if (expected_decodes.size() == 0) begin
                report_fault($sformatf("unexpected result valid=%0b code=%0d value=%0d",
                                       o_valid_res, o_signal_code, $signed(o_value_milli)));
            end else begin
                want = expected_decodes.pop_front();
                if (o_valid_res !== want.valid || o_signal_code !== want.code ||
                    o_value_milli !== want.value) begin
                    report_fault($sformatf(
                        "expected valid=%0b code=%0d value=%0d, got valid=%0b code=%0d value=%0d",
                        want.valid, want.code, $signed(want.value),
                        o_valid_res, o_signal_code, $signed(o_value_milli)));
                end
            end
        end
    end

    initial begin : run_tests
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_known_pids();
        wait_for_results(64);
        test_special_frames();
        wait_for_results(64);
        test_random_frames(1920);
        wait_for_results(256);
        repeat (4) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("obd_pid_value_decode_top regression: pass");
        end else begin
            $display("obd_pid_value_decode_top regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("obd_pid_value_decode_top regression: fail");
        $finish;
    end

endmodule
